/* hw/rtl/jfs_pkg.sv */
// ----------------------------------------------------------------------------
// jfs_pkg
// Shared constants and types of the JPEG frame size scanner.
// ----------------------------------------------------------------------------
package jfs_pkg;

  localparam int unsigned DIM_W     = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SOI    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SCAN_EOI  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_WIDTH  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_HEIGHT = 8'd3;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 16'd320;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 16'd240;

  localparam logic [BYTE_W-1:0] MK_FILL = 8'hFF;
  localparam logic [BYTE_W-1:0] MK_SOI  = 8'hD8;
  localparam logic [BYTE_W-1:0] MK_EOI  = 8'hD9;
  localparam logic [BYTE_W-1:0] MK_SOS  = 8'hDA;
  localparam logic [BYTE_W-1:0] MK_SOF0 = 8'hC0;
  localparam logic [BYTE_W-1:0] MK_SOF2 = 8'hC2;

  localparam logic [DIM_W-1:0] SEG_MIN_LEN = 16'd2;
  localparam logic [DIM_W-1:0] SOF_MIN_LEN = 16'd7;

  typedef struct packed {
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic [DIM_W-1:0]    use_width;
    logic [DIM_W-1:0]    use_height;
  } result_t;

endpackage

/* hw/rtl/jfs_if.sv */
// ----------------------------------------------------------------------------
// jfs_if
// Valid/ready channels of the JPEG frame size scanner.
// ----------------------------------------------------------------------------
interface jfs_in_if import jfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  modport source (output valid, data_byte, last, input ready);
  modport sink   (input valid, data_byte, last, output ready);
endinterface

interface jfs_out_if import jfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic [DIM_W-1:0]    image_width;
  logic [DIM_W-1:0]    image_height;
  logic [DIM_W-1:0]    use_width;
  logic [DIM_W-1:0]    use_height;

  modport source (output valid, found, status, image_width, image_height,
                  use_width, use_height, input ready);
  modport sink   (input valid, found, status, image_width, image_height,
                  use_width, use_height, output ready);
endinterface

interface jfs_cfg_if import jfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

/* hw/rtl/jpeg_frame_size_scanner.sv */
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner
// Finds the frame size in the SOF0/SOF2 header of a JPEG byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one file byte per transfer, last marks the final byte of a file.
//   out_ch : at most one result per file; found/status plus raw and usable
//            width and height (clamped, or the fallback registers on failure).
//   cfg_ch : register writes (0 max_width, 1 max_height, 2 fallback_width,
//            3 fallback_height); always ready, other indexes are dropped.
// Order: the byte that decides a result passes the input register, then the
//   result register, whose output drives out_ch.valid.
// Throughput: one byte per cycle while out_ch is not stalled; the per-byte
//   parser update between the two registers sets that figure.
// Reset: parser waits for FF D8, no result pending, registers take
//   320/240/320/240.
// Stall: a held result keeps the byte in the input register from advancing;
//   in_ch.ready drops while that register is full and the result register
//   holds a result that out_ch is not taking.
// ----------------------------------------------------------------------------
module jpeg_frame_size_scanner import jfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  jfs_in_if.sink    in_ch,
  jfs_out_if.source out_ch,
  jfs_cfg_if.sink   cfg_ch
);

  typedef enum logic [3:0] {
    PH_SOI0, PH_SOI1, PH_SEEK, PH_MARK, PH_LEN0, PH_LEN1, PH_PREC,
    PH_H0, PH_H1, PH_W0, PH_W1, PH_SKIP, PH_DONE
  } phase_t;

  logic [DIM_W-1:0] max_width_r, max_height_r, fb_width_r, fb_height_r;

  logic              stg_vld_r;
  logic [BYTE_W-1:0] stg_byte_r;
  logic              stg_last_r;

  phase_t            phase_r, phase_nxt;
  logic [DIM_W-1:0]  left_r, left_nxt;
  logic [BYTE_W-1:0] marker_r, marker_nxt;
  logic [BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [DIM_W-1:0]  hdr_h_r, hdr_h_nxt;
  logic [DIM_W-1:0]  hdr_w_r, hdr_w_nxt;
  logic              given_r, given_nxt;

  logic              out_valid_r;
  result_t           out_r, res;
  logic              res_vld;

  logic              out_free, stg_adv;
  logic [BYTE_W-1:0] b;
  logic              is_sof;
  logic [DIM_W-1:0]  seglen, left_dec;
  logic              body_done, ok, fail;
  logic [STATUS_W-1:0] fail_code;
  phase_t            phase_step;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_width_r  <= RST_WIDTH;
      max_height_r <= RST_HEIGHT;
      fb_width_r   <= RST_WIDTH;
      fb_height_r  <= RST_HEIGHT;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MAX_WIDTH:       max_width_r  <= cfg_ch.wdata;
        REG_MAX_HEIGHT:      max_height_r <= cfg_ch.wdata;
        REG_FALLBACK_WIDTH:  fb_width_r   <= cfg_ch.wdata;
        REG_FALLBACK_HEIGHT: fb_height_r  <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  assign out_free    = !out_valid_r || out_ch.ready;
  assign stg_adv     = stg_vld_r && out_free;
  assign in_ch.ready = !stg_vld_r || stg_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stg_byte_r <= in_ch.data_byte;
      stg_last_r <= in_ch.last;
    end
  end

  assign b         = stg_byte_r;
  assign is_sof    = (marker_r == MK_SOF0) || (marker_r == MK_SOF2);
  assign seglen    = {len_hi_r, b};
  assign left_dec  = (left_r != '0) ? left_r - 1'b1 : left_r;
  assign body_done = (left_dec == '0);

  always_comb begin
    phase_step = phase_r;
    left_nxt   = left_r;
    marker_nxt = marker_r;
    len_hi_nxt = len_hi_r;
    hdr_h_nxt  = hdr_h_r;
    hdr_w_nxt  = hdr_w_r;
    given_nxt  = given_r;
    ok         = 1'b0;
    fail       = 1'b0;
    fail_code  = ST_NO_SOI;
    case (phase_r)
      PH_SOI0: begin
        if (b == MK_FILL) phase_step = PH_SOI1; else fail = 1'b1;
      end
      PH_SOI1: begin
        if (b == MK_SOI) phase_step = PH_SEEK; else fail = 1'b1;
      end
      PH_SEEK: begin
        if (b == MK_FILL) phase_step = PH_MARK;
      end
      PH_MARK: begin
        if (b == MK_EOI || b == MK_SOS) begin
          fail      = 1'b1;
          fail_code = ST_SCAN_EOI;
        end else if (b != MK_FILL) begin
          marker_nxt = b;
          phase_step = PH_LEN0;
        end
      end
      PH_LEN0: begin
        len_hi_nxt = b;
        phase_step = PH_LEN1;
      end
      PH_LEN1: begin
        if (seglen < SEG_MIN_LEN || (is_sof && seglen < SOF_MIN_LEN)) begin
          fail      = 1'b1;
          fail_code = ST_BAD_LEN;
        end else begin
          left_nxt = seglen - SEG_MIN_LEN;
          if (is_sof)                    phase_step = PH_PREC;
          else if (seglen == SEG_MIN_LEN) phase_step = PH_SEEK;
          else                           phase_step = PH_SKIP;
        end
      end
      PH_PREC: begin
        left_nxt   = left_dec;
        phase_step = PH_H0;
      end
      PH_H0: begin
        hdr_h_nxt  = {b, {BYTE_W{1'b0}}};
        left_nxt   = left_dec;
        phase_step = PH_H1;
      end
      PH_H1: begin
        hdr_h_nxt  = hdr_h_r | {{BYTE_W{1'b0}}, b};
        left_nxt   = left_dec;
        phase_step = PH_W0;
      end
      PH_W0: begin
        hdr_w_nxt  = {b, {BYTE_W{1'b0}}};
        left_nxt   = left_dec;
        phase_step = PH_W1;
      end
      PH_W1: begin
        hdr_w_nxt = hdr_w_r | {{BYTE_W{1'b0}}, b};
        left_nxt  = left_dec;
        if (body_done) ok = 1'b1; else phase_step = PH_SKIP;
      end
      PH_SKIP: begin
        left_nxt = left_dec;
        if (body_done) begin
          if (is_sof) ok = 1'b1; else phase_step = PH_SEEK;
        end
      end
      default: ;
    endcase

    if (ok || fail) begin
      given_nxt  = 1'b1;
      phase_step = PH_DONE;
    end

    res_vld = ok || fail;
    if (ok) begin
      res.found        = 1'b1;
      res.status       = ST_FOUND;
      res.image_width  = hdr_w_nxt;
      res.image_height = hdr_h_nxt;
      res.use_width    = (hdr_w_nxt > max_width_r)  ? max_width_r  : hdr_w_nxt;
      res.use_height   = (hdr_h_nxt > max_height_r) ? max_height_r : hdr_h_nxt;
    end else begin
      res.found        = 1'b0;
      res.status       = fail_code;
      res.image_width  = '0;
      res.image_height = '0;
      res.use_width    = fb_width_r;
      res.use_height   = fb_height_r;
    end

    phase_nxt = phase_step;
    if (stg_last_r) begin
      if (!res_vld && !given_r) begin
        res_vld = 1'b1;
        res.status = (phase_step == PH_SOI0 || phase_step == PH_SOI1) ?
                     ST_NO_SOI : ST_TRUNCATED;
      end
      phase_nxt  = PH_SOI0;
      left_nxt   = '0;
      marker_nxt = '0;
      len_hi_nxt = '0;
      hdr_h_nxt  = '0;
      hdr_w_nxt  = '0;
      given_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SOI0;
      left_r      <= '0;
      marker_r    <= '0;
      len_hi_r    <= '0;
      hdr_h_r     <= '0;
      hdr_w_r     <= '0;
      given_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (stg_adv) begin
        phase_r  <= phase_nxt;
        left_r   <= left_nxt;
        marker_r <= marker_nxt;
        len_hi_r <= len_hi_nxt;
        hdr_h_r  <= hdr_h_nxt;
        hdr_w_r  <= hdr_w_nxt;
        given_r  <= given_nxt;
      end
      out_valid_r <= stg_adv ? res_vld : (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv && res_vld) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_r.found;
  assign out_ch.status       = out_r.status;
  assign out_ch.image_width  = out_r.image_width;
  assign out_ch.image_height = out_r.image_height;
  assign out_ch.use_width    = out_r.use_width;
  assign out_ch.use_height   = out_r.use_height;

endmodule

/* hw/rtl/jfs_checker.sv */
// ----------------------------------------------------------------------------
// jfs_checker
// Port-level checks of the JPEG frame size scanner, bound to the top level.
// ----------------------------------------------------------------------------
module jfs_checker import jfs_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_found,
  input logic [STATUS_W-1:0] out_status,
  input logic [DIM_W-1:0]    out_image_width,
  input logic [DIM_W-1:0]    out_image_height,
  input logic [DIM_W-1:0]    out_use_width,
  input logic [DIM_W-1:0]    out_use_height
);

  a_no_result_after_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_use_width) && $stable(out_use_height))
    else $error("stalled result changed");

  a_found_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_FOUND
      && out_use_width <= out_image_width && out_use_height <= out_image_height)
    else $error("found result inconsistent with clamp");

  a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_status != ST_FOUND
      && out_image_width == '0 && out_image_height == '0)
    else $error("failed result carries a size");

endmodule

bind jpeg_frame_size_scanner jfs_checker u_jfs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_found        (out_ch.found),
  .out_status       (out_ch.status),
  .out_image_width  (out_ch.image_width),
  .out_image_height (out_ch.image_height),
  .out_use_width    (out_ch.use_width),
  .out_use_height   (out_ch.use_height)
);

/* tb/tb_jpeg_frame_size_scanner.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_jpeg_frame_size_scanner
// Streams JPEG-like files byte by byte through the scanner and checks the one
// size result per file against a byte-level parser kept in a scoreboard.
// Files are mostly well formed (segments, fill runs, stray bytes, SOF0/SOF2)
// with truncated, corrupted and noise files mixed in. Register settings change
// between phases while the block is idle; both channels idle at random.
// ----------------------------------------------------------------------------
module tb_jpeg_frame_size_scanner;
  import jfs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [BYTE_W-1:0] MK_NULL = 8'h00;
  localparam logic [BYTE_W-1:0] MK_RST0 = 8'hD0;
  localparam logic [BYTE_W-1:0] MK_APP0 = 8'hE0;

  localparam int SEG_PLAIN   = 0;
  localparam int SEG_FRAME   = 1;
  localparam int SEG_BAD_LEN = 2;
  localparam int SEG_STOP    = 3;

  typedef enum logic [3:0] {
    P_SOI0, P_SOI1, P_SEEK, P_MARK, P_LEN0, P_LEN1, P_PREC,
    P_H0, P_H1, P_W0, P_W1, P_SKIP, P_DONE
  } scan_phase_t;

  class frame_size_scoreboard;
    logic [DIM_W-1:0]  max_w, max_h, fb_w, fb_h;
    scan_phase_t       phase;
    logic [DIM_W-1:0]  body_left;
    logic [BYTE_W-1:0] marker, len_hi;
    logic [DIM_W-1:0]  hdr_h, hdr_w;
    bit                reported;
    result_t           sizes_due[$];
    int                fails;

    function new();
      max_w = RST_WIDTH;
      max_h = RST_HEIGHT;
      fb_w  = RST_WIDTH;
      fb_h  = RST_HEIGHT;
      fails = 0;
      clear_file();
    endfunction

    function void clear_file();
      phase     = P_SOI0;
      body_left = '0;
      marker    = '0;
      len_hi    = '0;
      hdr_h     = '0;
      hdr_w     = '0;
      reported  = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
      case (idx)
        REG_MAX_WIDTH:       max_w = v;
        REG_MAX_HEIGHT:      max_h = v;
        REG_FALLBACK_WIDTH:  fb_w  = v;
        REG_FALLBACK_HEIGHT: fb_h  = v;
        default: ;
      endcase
    endfunction

    function result_t fallback_size(logic [STATUS_W-1:0] st);
      result_t r;
      r.found        = 1'b0;
      r.status       = st;
      r.image_width  = '0;
      r.image_height = '0;
      r.use_width    = fb_w;
      r.use_height   = fb_h;
      return r;
    endfunction

    // true once the segment body is used up
    function bit eat_body();
      if (body_left != 0) body_left = body_left - 1'b1;
      return body_left == 0;
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b, logic lst);
      result_t          r;
      bit               ok, bad, sof;
      logic [STATUS_W-1:0] st;
      logic [DIM_W-1:0] seglen;
      ok  = 1'b0;
      bad = 1'b0;
      st  = ST_FOUND;
      sof = (marker == MK_SOF0) || (marker == MK_SOF2);
      case (phase)
        P_SOI0: begin
          if (b == MK_FILL) phase = P_SOI1;
          else begin bad = 1'b1; st = ST_NO_SOI; end
        end
        P_SOI1: begin
          if (b == MK_SOI) phase = P_SEEK;
          else begin bad = 1'b1; st = ST_NO_SOI; end
        end
        P_SEEK: if (b == MK_FILL) phase = P_MARK;
        P_MARK: begin
          if (b == MK_EOI || b == MK_SOS) begin
            bad = 1'b1;
            st  = ST_SCAN_EOI;
          end else if (b != MK_FILL) begin
            marker = b;
            phase  = P_LEN0;
          end
        end
        P_LEN0: begin
          len_hi = b;
          phase  = P_LEN1;
        end
        P_LEN1: begin
          seglen = {len_hi, b};
          if (seglen < SEG_MIN_LEN || (sof && seglen < SOF_MIN_LEN)) begin
            bad = 1'b1;
            st  = ST_BAD_LEN;
          end else begin
            body_left = seglen - SEG_MIN_LEN;
            if (sof) phase = P_PREC;
            else phase = (body_left == 0) ? P_SEEK : P_SKIP;
          end
        end
        P_PREC: begin
          void'(eat_body());
          phase = P_H0;
        end
        P_H0: begin
          hdr_h = {b, 8'h00};
          void'(eat_body());
          phase = P_H1;
        end
        P_H1: begin
          hdr_h[7:0] = b;
          void'(eat_body());
          phase = P_W0;
        end
        P_W0: begin
          hdr_w = {b, 8'h00};
          void'(eat_body());
          phase = P_W1;
        end
        P_W1: begin
          hdr_w[7:0] = b;
          if (eat_body()) ok = 1'b1;
          else phase = P_SKIP;
        end
        P_SKIP: begin
          if (eat_body()) begin
            if (sof) ok = 1'b1;
            else phase = P_SEEK;
          end
        end
        default: ;
      endcase

      if (ok) begin
        r.found        = 1'b1;
        r.status       = ST_FOUND;
        r.image_width  = hdr_w;
        r.image_height = hdr_h;
        r.use_width    = (hdr_w > max_w) ? max_w : hdr_w;
        r.use_height   = (hdr_h > max_h) ? max_h : hdr_h;
        sizes_due.push_back(r);
        reported = 1'b1;
        phase    = P_DONE;
      end else if (bad) begin
        sizes_due.push_back(fallback_size(st));
        reported = 1'b1;
        phase    = P_DONE;
      end

      if (lst) begin
        if (!reported) begin
          if (phase == P_SOI0 || phase == P_SOI1)
            sizes_due.push_back(fallback_size(ST_NO_SOI));
          else
            sizes_due.push_back(fallback_size(ST_TRUNCATED));
        end
        clear_file();
      end
    endfunction

    function void check_size_result(result_t got);
      result_t want;
      if (sizes_due.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: found=%0d status=%0d w=%0d h=%0d uw=%0d uh=%0d",
                   got.found, got.status, got.image_width, got.image_height,
                   got.use_width, got.use_height);
        return;
      end
      want = sizes_due.pop_front();
      if (got.found !== want.found || got.status !== want.status ||
          got.image_width !== want.image_width ||
          got.image_height !== want.image_height ||
          got.use_width !== want.use_width || got.use_height !== want.use_height) begin
        fails++;
        if (fails <= 10)
          $display("mismatch at %0t: exp found=%0d status=%0d w=%0d h=%0d uw=%0d uh=%0d",
                   $realtime, want.found, want.status, want.image_width,
                   want.image_height, want.use_width, want.use_height,
                   "\n                 got found=%0d status=%0d w=%0d h=%0d uw=%0d uh=%0d",
                   got.found, got.status, got.image_width, got.image_height,
                   got.use_width, got.use_height);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  jfs_in_if  in_if ();
  jfs_out_if out_if ();
  jfs_cfg_if cfg_if ();

  jpeg_frame_size_scanner dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  frame_size_scoreboard sb;
  logic [BYTE_W-1:0]    file_q[$];
  int                   burst_left;
  int                   quiet_cycles;
  int                   rx_cycle;
  int                   stall_pct;
  int                   stall_left;

  always #6 clk = ~clk;

  // transfer monitor and watchdog
  always @(posedge clk) begin
    result_t got;
    bit      moved;
    moved = 1'b0;
    if (rst_n === 1'b1) begin
      if (cfg_if.valid && cfg_if.ready) begin
        sb.set_reg(cfg_if.index, cfg_if.wdata);
        moved = 1'b1;
      end
      if (in_if.valid && in_if.ready) begin
        sb.take_byte(in_if.data_byte, in_if.last);
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        got.found        = out_if.found;
        got.status       = out_if.status;
        got.image_width  = out_if.image_width;
        got.image_height = out_if.image_height;
        got.use_width    = out_if.use_width;
        got.use_height   = out_if.use_height;
        sb.check_size_result(got);
        moved = 1'b1;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side stalls; the stall rate is redrawn as rx_cycle advances
  initial out_if.ready = 1'b0;
  always @(negedge clk) begin
    if (rx_cycle % 200 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 15;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    rx_cycle++;
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready = 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 11);
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic lst);
    if (burst_left == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
    in_if.valid     = 1'b1;
    in_if.data_byte = b;
    in_if.last      = lst;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++)
      push_byte(file_q[i], i == file_q.size() - 1);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.wdata = v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input int ph);
    logic [DIM_W-1:0] v[4];
    case (ph)
      1: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      2: v = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
      3: v = '{16'h0001, 16'h0001, 16'h0001, 16'h0001};
      4: begin
        foreach (v[i]) v[i] = DIM_W'($urandom);
        cfg_write(CFG_IDX_W'($urandom_range(4, 255)), DIM_W'($urandom));
      end
      default: begin
        v[0] = DIM_W'($urandom_range(1, 300));
        v[1] = DIM_W'($urandom_range(1, 300));
        v[2] = DIM_W'($urandom);
        v[3] = DIM_W'($urandom);
      end
    endcase
    cfg_write(REG_MAX_WIDTH, v[0]);
    cfg_write(REG_MAX_HEIGHT, v[1]);
    cfg_write(REG_FALLBACK_WIDTH, v[2]);
    cfg_write(REG_FALLBACK_HEIGHT, v[3]);
    cfg_if.valid = 1'b0;
  endtask

  // wait for every result, then let the pipeline drain bytes with no result
  task automatic settle();
    in_if.valid = 1'b0;
    burst_left  = 0;
    while (sb.sizes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return DIM_W'($urandom);
      default: return DIM_W'($urandom_range(1, 400));
    endcase
  endfunction

  function automatic void add_segment(input int kind);
    logic [BYTE_W-1:0] m;
    logic [DIM_W-1:0]  len, h, w;
    int                body;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) file_q.push_back(BYTE_W'($urandom_range(0, 254)));
    repeat ($urandom_range(1, 3)) file_q.push_back(MK_FILL);
    if (kind == SEG_STOP) begin
      file_q.push_back($urandom_range(0, 1) ? MK_EOI : MK_SOS);
      return;
    end
    if (kind == SEG_FRAME || (kind == SEG_BAD_LEN && $urandom_range(0, 1))) begin
      m = $urandom_range(0, 1) ? MK_SOF0 : MK_SOF2;
    end else begin
      case ($urandom_range(0, 3))
        0: m = MK_SOI;
        1: m = MK_NULL;
        2: m = BYTE_W'(MK_RST0 + $urandom_range(0, 7));
        default: begin
          m = BYTE_W'($urandom_range(0, 254));
          if (m == MK_EOI || m == MK_SOS || m == MK_SOF0 || m == MK_SOF2) m = MK_APP0;
        end
      endcase
    end
    file_q.push_back(m);
    if (kind == SEG_BAD_LEN) begin
      len = (m == MK_SOF0 || m == MK_SOF2) ? DIM_W'($urandom_range(0, 6))
                                           : DIM_W'($urandom_range(0, 1));
      body = 4;
    end else if ($urandom_range(0, 15) == 0) begin
      len = DIM_W'($urandom);
      body = 12;
    end else if (kind == SEG_FRAME) begin
      body = 5 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4));
      len  = DIM_W'(body + 2);
    end else begin
      body = $urandom_range(0, 6);
      len  = DIM_W'(body + 2);
    end
    file_q.push_back(len[15:8]);
    file_q.push_back(len[7:0]);
    if (kind == SEG_FRAME) begin
      h = pick_dim();
      w = pick_dim();
      file_q.push_back(BYTE_W'($urandom_range(0, 255)));
      file_q.push_back(h[15:8]);
      file_q.push_back(h[7:0]);
      file_q.push_back(w[15:8]);
      file_q.push_back(w[7:0]);
      body -= 5;
    end
    repeat (body) file_q.push_back(BYTE_W'($urandom_range(0, 255)));
  endfunction

  function automatic void make_file();
    int kind;
    file_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      if ($urandom_range(0, 1)) file_q.push_back(MK_FILL);
      repeat ($urandom_range(1, 16)) file_q.push_back(BYTE_W'($urandom_range(0, 255)));
      return;
    end
    file_q.push_back(MK_FILL);
    file_q.push_back(MK_SOI);
    repeat ($urandom_range(0, 3)) add_segment(SEG_PLAIN);
    if (kind < 20)      add_segment(SEG_STOP);
    else if (kind < 28) add_segment(SEG_BAD_LEN);
    else if (kind < 33) ;
    else                add_segment(SEG_FRAME);
    repeat ($urandom_range(0, 3)) file_q.push_back(BYTE_W'($urandom_range(0, 255)));
    if ($urandom_range(0, 19) == 0)
      file_q[$urandom_range(0, file_q.size() - 1)] = BYTE_W'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0)
      file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
  endfunction

  initial begin
    int sent;
    int nfiles;
    sb              = new();
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last      = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.wdata    = '0;
    burst_left      = 0;
    quiet_cycles    = 0;
    rx_cycle        = 0;
    stall_left      = 0;
    stall_pct       = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: bad first byte, bad second byte, stop marker after a fill run,
    // length below two, then a minimal SOF0 with maximal size and a tail byte
    file_q = '{MK_NULL};
    send_file();
    file_q = '{MK_FILL, MK_FILL};
    send_file();
    file_q = '{MK_FILL, MK_SOI, MK_FILL, MK_FILL, MK_SOS};
    send_file();
    file_q = '{MK_FILL, MK_SOI, MK_FILL, MK_APP0, 8'h00, 8'h01};
    send_file();
    file_q = '{MK_FILL, MK_SOI, MK_FILL, MK_SOF0, 8'h00, 8'h07, 8'h08,
               8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_file();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        settle();
        configure(ph);
      end
      sent   = 0;
      nfiles = 0;
      while (sent < 165 || nfiles < 6) begin
        make_file();
        sent += file_q.size();
        nfiles++;
        send_file();
      end
    end

    in_if.valid = 1'b0;
    while (sb.sizes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.sizes_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
